/* sv/movdec_pkg.sv */
// Shared types, constants and helper functions of the MOV instruction byte decoder.
`default_nettype none

package movdec_pkg;

	// Opcode prefixes of the two decoded MOV forms.
	localparam logic [5:0] OPC_REG_RM_PREFIX = 6'b100010;
	localparam logic [3:0] OPC_IMM_PREFIX    = 4'b1011;

	// ModRM field codes that change the operand form.
	localparam logic [1:0] MOD_NO_DISP  = 2'b00;
	localparam logic [1:0] MOD_DISP8    = 2'b01;
	localparam logic [1:0] MOD_REGISTER = 2'b11;
	localparam logic [2:0] RM_DIRECT    = 3'b110;

	typedef enum logic [1:0] {
		KIND_MOV_RM  = 2'd0,
		KIND_MOV_IMM = 2'd1,
		KIND_UNKNOWN = 2'd2
	} instr_kind_t;

	typedef enum logic [1:0] {
		OTHER_REG    = 2'd0,
		OTHER_EA     = 2'd1,
		OTHER_DIRECT = 2'd2,
		OTHER_IMM    = 2'd3
	} other_kind_t;

	// One input item.
	typedef struct packed {
		logic [7:0] code_byte;
	} code_item_t;

	// One decoded record, as delivered on the output channel.
	typedef struct packed {
		instr_kind_t instr_kind;
		logic        wide;
		logic [3:0]  reg_operand;
		logic        reg_is_dest;
		other_kind_t other_kind;
		logic [3:0]  other_register;
		logic [2:0]  address_form;
		logic        has_value;
		logic [15:0] value;
		logic [2:0]  length;
	} record_t;

	// A collected instruction, passed from the front end to the back end.
	typedef struct packed {
		instr_kind_t kind;
		logic [7:0]  opcode;
		logic [7:0]  modrm;
		logic        has_value;
		logic        two_bytes;
		logic [15:0] value;
	} decode_t;

	typedef struct packed {
		logic    valid;
		decode_t entry;
	} push_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	function automatic logic is_reg_rm(input logic [7:0] op);
		return op[7:2] == OPC_REG_RM_PREFIX;
	endfunction

	function automatic logic is_imm_reg(input logic [7:0] op);
		return op[7:4] == OPC_IMM_PREFIX;
	endfunction

endpackage

`default_nettype wire

/* sv/movdec_stream_if.sv */
// Valid/ready stream channel carrying one item of a given payload type.
`default_nettype none

interface movdec_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/mov_instruction_byte_decoder_top.sv */
// Top level of the byte-serial decoder for the two 16-bit x86 MOV instruction forms.
// The block takes an x86 code stream one byte per item on code_ch and delivers one decoded
// record on record_ch after the last byte of every instruction: MOV reg/rm (100010dw, ModRM,
// zero to two displacement or direct-address bytes) and MOV immediate to register (1011wrrr,
// one or two immediate bytes, low byte first). Any other first byte yields an unknown record
// of length one. It accepts one code byte every cycle; a record enters the instruction queue
// when its last byte is accepted and moves to the output register when popped. The front
// end tracks the position within the current instruction and never stalls by itself; it
// stops taking bytes only when the queue, QUEUE_DEPTH entries deep, is full, which for a
// depth above one happens only after the sink has held ready low. The back end expands a
// queued instruction into a record and keeps it in an output register until the sink takes
// it, so a new byte is taken while a finished record still waits. An 8-bit displacement and
// an 8-bit immediate are zero-extended; a direct address always takes two bytes.
`default_nettype none

module mov_instruction_byte_decoder_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	movdec_stream_if.sink    code_ch,
	movdec_stream_if.source  record_ch
);
	import movdec_pkg::*;

	push_t         push;
	decode_t       head;
	queue_status_t qstat;
	logic          pop;

	// Front end: byte sequencing and instruction collection.
	movdec_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.code_ch (code_ch),
		.qstat   (qstat),
		.push    (push)
	);

	// Decoupling queue: lets the byte side run while the record side stalls.
	movdec_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// Back end: record formatting and the output register.
	movdec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.record_ch (record_ch)
	);

endmodule

`default_nettype wire

/* sv/movdec_front.sv */
// Front end: collects code bytes into whole instructions and pushes them to the queue.
`default_nettype none

module movdec_front (
	input  wire                        clk,
	input  wire                        arst_n,
	movdec_stream_if.sink              code_ch,
	input  movdec_pkg::queue_status_t  qstat,
	output movdec_pkg::push_t          push
);
	import movdec_pkg::*;

	typedef enum logic [1:0] {
		P_OPCODE,
		P_MODRM,
		P_VAL_LO,
		P_VAL_HI
	} phase_t;

	phase_t     phase_q;
	logic [7:0] opcode_q;
	logic [7:0] modrm_q;
	logic [7:0] low_q;
	logic       two_q;

	logic       accept;
	logic [7:0] b;
	logic       no_disp;

	assign code_ch.ready = !qstat.full;
	assign accept        = code_ch.valid && code_ch.ready;
	assign b             = code_ch.data.code_byte;

	// A ModRM byte ends the instruction when it names a register or an
	// address form without displacement.
	assign no_disp = (b[7:6] == MOD_REGISTER) ||
	                 ((b[7:6] == MOD_NO_DISP) && (b[2:0] != RM_DIRECT));

	always_comb begin
		push                 = '0;
		push.entry.kind      = is_reg_rm(opcode_q) ? KIND_MOV_RM : KIND_MOV_IMM;
		push.entry.opcode    = opcode_q;
		push.entry.modrm     = modrm_q;
		unique case (phase_q)
			P_OPCODE: begin
				if (!is_reg_rm(b) && !is_imm_reg(b)) begin
					push.valid      = accept;
					push.entry      = '0;
					push.entry.kind = KIND_UNKNOWN;
				end
			end
			P_MODRM: begin
				push.entry.modrm = b;
				push.valid       = accept && no_disp;
			end
			P_VAL_LO: begin
				push.valid           = accept && !two_q;
				push.entry.has_value = 1'b1;
				push.entry.value     = {8'h00, b};
			end
			P_VAL_HI: begin
				push.valid           = accept;
				push.entry.has_value = 1'b1;
				push.entry.two_bytes = 1'b1;
				push.entry.value     = {b, low_q};
			end
			default: push.valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= P_OPCODE;
			opcode_q <= '0;
			modrm_q  <= '0;
			low_q    <= '0;
			two_q    <= 1'b0;
		end else if (accept) begin
			unique case (phase_q)
				P_OPCODE: begin
					if (is_reg_rm(b)) begin
						opcode_q <= b;
						phase_q  <= P_MODRM;
					end else if (is_imm_reg(b)) begin
						opcode_q <= b;
						two_q    <= b[3];
						phase_q  <= P_VAL_LO;
					end
				end
				P_MODRM: begin
					modrm_q <= b;
					two_q   <= (b[7:6] != MOD_DISP8);
					phase_q <= no_disp ? P_OPCODE : P_VAL_LO;
				end
				P_VAL_LO: begin
					low_q   <= b;
					phase_q <= two_q ? P_VAL_HI : P_OPCODE;
				end
				P_VAL_HI: phase_q <= P_OPCODE;
				default:  phase_q <= P_OPCODE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/movdec_queue.sv */
// Short first-in first-out queue of collected instructions between front and back end.
`default_nettype none

module movdec_queue #(
	parameter int DEPTH = 2
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  movdec_pkg::push_t          push,
	input  wire                        pop,
	output movdec_pkg::decode_t        head,
	output movdec_pkg::queue_status_t  qstat
);
	import movdec_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	decode_t          entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == FULL_CNT);
	assign do_push     = push.valid && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/movdec_back.sv */
// Back end: expands a collected instruction into a decoded record and holds it for the sink.
`default_nettype none

module movdec_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  movdec_pkg::decode_t        head,
	input  movdec_pkg::queue_status_t  qstat,
	output logic                       pop,
	movdec_stream_if.source            record_ch
);
	import movdec_pkg::*;

	record_t    rec;
	record_t    rec_q;
	logic       valid_q;
	logic [1:0] md;
	logic [2:0] rm;
	logic       w;
	logic [2:0] val_bytes;

	assign md  = head.modrm[7:6];
	assign rm  = head.modrm[2:0];
	assign pop = !qstat.empty && (!valid_q || record_ch.ready);

	always_comb begin
		rec            = '0;
		w              = 1'b0;
		val_bytes      = head.has_value ? (head.two_bytes ? 3'd2 : 3'd1) : 3'd0;
		rec.instr_kind = head.kind;
		unique case (head.kind)
			KIND_MOV_RM: begin
				w               = head.opcode[0];
				rec.wide        = w;
				rec.reg_operand = {w, head.modrm[5:3]};
				rec.reg_is_dest = head.opcode[1];
				if (md == MOD_REGISTER) begin
					rec.other_kind     = OTHER_REG;
					rec.other_register = {w, rm};
				end else if (md == MOD_NO_DISP && rm == RM_DIRECT) begin
					rec.other_kind = OTHER_DIRECT;
				end else begin
					rec.other_kind   = OTHER_EA;
					rec.address_form = rm;
				end
				rec.has_value = head.has_value;
				rec.value     = head.value;
				rec.length    = 3'd2 + val_bytes;
			end
			KIND_MOV_IMM: begin
				w               = head.opcode[3];
				rec.wide        = w;
				rec.reg_operand = {w, head.opcode[2:0]};
				rec.reg_is_dest = 1'b1;
				rec.other_kind  = OTHER_IMM;
				rec.has_value   = head.has_value;
				rec.value       = head.value;
				rec.length      = 3'd1 + val_bytes;
			end
			default: begin
				rec.instr_kind = KIND_UNKNOWN;
				rec.length     = 3'd1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (record_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	assign record_ch.valid = valid_q;
	assign record_ch.data  = rec_q;

endmodule

`default_nettype wire

/* sv/movdec_checker.sv */
// Port-level assertions of the MOV decoder and their binding to the top level.
`default_nettype none

module movdec_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  out_valid,
	input wire                  out_ready,
	input movdec_pkg::record_t  out_rec
);
	import movdec_pkg::*;

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("record withdrawn while stalled");

	a_record_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_rec))
		else $error("record changed while stalled");

	a_unknown_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rec.instr_kind == KIND_UNKNOWN |->
		out_rec.length == 3'd1 && !out_rec.has_value && out_rec.value == 16'd0)
		else $error("unknown record is not a bare one-byte record");

	a_imm_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rec.instr_kind == KIND_MOV_IMM |->
		out_rec.has_value && out_rec.length == (out_rec.wide ? 3'd3 : 3'd2))
		else $error("immediate record length does not match its width");

	a_no_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_rec.has_value |-> out_rec.value == 16'd0)
		else $error("value present without has_value");

endmodule

bind mov_instruction_byte_decoder_top movdec_checker u_movdec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (record_ch.valid),
	.out_ready (record_ch.ready),
	.out_rec   (record_ch.data)
);

`default_nettype wire
